/* hdl/mhc_pkg.sv */
// Shared types, constants and the mask inverse table for the masked Hill cipher block.
`timescale 1ns / 1ps

package mhc_pkg;

    // Byte-wide data and a triple of bytes (one per matrix row or column).
    typedef logic [7:0]      t_byte;
    typedef logic [2:0][7:0] t_byte3;

    // Generator geometry.
    localparam int GEN_W            = 128;
    localparam int HALF_W           = 64;
    localparam int SHIFTS_PER_CYCLE = 8;
    localparam int STEP_W           = $clog2(SHIFTS_PER_CYCLE + 1);
    localparam int MAX_DRAWS        = 128;
    localparam int DRAW_W           = $clog2(MAX_DRAWS);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int KEY_ROW_W  = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_ROW_FIRST  = 3'd0,
        CFG_KEY_ROW_SECOND = 3'd1,
        CFG_KEY_ROW_THIRD  = 3'd2,
        CFG_SEED_LOW       = 3'd3,
        CFG_SEED_HIGH      = 3'd4
    } t_cfg_index;

    // Operation codes.
    localparam logic OP_LOCK   = 1'b0;
    localparam logic OP_UNLOCK = 1'b1;

    // Control from the sequencer to the generator.
    typedef struct packed {
        logic              seed_low_we;
        logic              seed_high_we;
        logic              shift_en;
        logic [STEP_W-1:0] steps;
    } t_gen_ctrl;

    // Control from the sequencer to the byte lanes.
    typedef struct packed {
        logic mask_en;
        logic prod_en;
    } t_lane_ctrl;

    // Inverse modulo 256 of every odd byte, indexed by bits 7:1 of the byte.
    typedef logic [127:0][7:0] t_inv_table;

    function automatic t_inv_table f_build_inv();
        t_inv_table tbl;
        int unsigned m;
        int unsigned inv;
        for (int i = 0; i < 128; i++) begin
            m   = 2 * i + 1;
            inv = m;
            // Three Newton steps double the number of correct bits each time.
            for (int k = 0; k < 3; k++) begin
                inv = (inv * ((2 - ((m * inv) & 8'hFF)) & 8'hFF)) & 8'hFF;
            end
            tbl[i] = inv[7:0];
        end
        return tbl;
    endfunction

    localparam t_inv_table INV_TABLE = f_build_inv();

endpackage

/* hdl/mhc_lfsr.sv */
// Mask generator: 128-bit right-shifting LFSR that advances up to eight shifts per cycle.
`timescale 1ns / 1ps

module mhc_lfsr
    import mhc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_gen_ctrl             i_ctrl,
    input  logic [CFG_DATA_W-1:0] i_seed_data,
    output t_byte                 o_next_low
);

    logic [HALF_W-1:0] r_seed_low;
    logic [HALF_W-1:0] r_seed_high;
    logic [GEN_W-1:0]  r_gen;
    logic [GEN_W-1:0]  n_gen;

    // Advance the generator by the requested number of single shifts.
    always_comb begin
        logic fb;
        n_gen = r_gen;
        for (int i = 0; i < SHIFTS_PER_CYCLE; i++) begin
            fb = n_gen[0] ^ n_gen[1] ^ n_gen[2] ^ n_gen[7];
            if (i < int'(i_ctrl.steps)) begin
                n_gen = {fb, n_gen[GEN_W-1:1]};
            end
        end
    end

    // The low byte after this cycle's shifts tells the sequencer whether the draw is odd.
    assign o_next_low = n_gen[7:0];

    // Seed registers and generator; a seed write reloads the whole generator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_low  <= HALF_W'(1);
            r_seed_high <= '0;
            r_gen       <= {{HALF_W{1'b0}}, HALF_W'(1)};
        end else if (i_ctrl.seed_low_we) begin
            r_seed_low <= i_seed_data;
            r_gen      <= {r_seed_high, i_seed_data};
        end else if (i_ctrl.seed_high_we) begin
            r_seed_high <= i_seed_data;
            r_gen       <= {i_seed_data, r_seed_low};
        end else if (i_ctrl.shift_en) begin
            r_gen <= n_gen;
        end
    end

endmodule

/* hdl/mhc_lane.sv */
// Byte lane: masks one input byte and forms its products with one key matrix column.
`timescale 1ns / 1ps

module mhc_lane
    import mhc_pkg::*;
(
    input  logic       i_clk,
    input  t_lane_ctrl i_ctrl,
    input  t_byte      i_byte,
    input  t_byte      i_factor,
    input  t_byte3     i_key_col,
    output t_byte3     o_prod
);

    logic [15:0] w_masked;
    t_byte       r_masked;
    t_byte3      r_prod;

    assign w_masked = i_byte * i_factor;

    // First stage: the byte times the mask (or its inverse), modulo 256.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mask_en) begin
            r_masked <= w_masked[7:0];
        end
    end

    // Second stage: one product per matrix row, modulo 256.
    always_ff @(posedge i_clk) begin
        logic [15:0] prod;
        if (i_ctrl.prod_en) begin
            for (int r = 0; r < 3; r++) begin
                prod      = i_key_col[r] * r_masked;
                r_prod[r] <= prod[7:0];
            end
        end
    end

    assign o_prod = r_prod;

endmodule

/* hdl/mhc_merge.sv */
// Merge stage: sums the lane products per row modulo 256 and forces zeros on a stuck generator.
`timescale 1ns / 1ps

module mhc_merge
    import mhc_pkg::*;
(
    input  t_byte3 i_prod [3],
    input  logic   i_stuck,
    output t_byte3 o_bytes
);

    // Each output byte is the row sum across the three lanes; bytes wrap modulo 256.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            o_bytes[r] = i_stuck ? '0 : t_byte'(i_prod[0][r] + i_prod[1][r] + i_prod[2][r]);
        end
    end

endmodule

/* hdl/masked_hill_cipher_3byte_top.sv */
// Top level of the masked 3x3 Hill cipher: sequencer, key registers, lanes and output register.
`timescale 1ns / 1ps

// The block takes one byte triple per transfer and returns one result transfer for it.
// Once an item is accepted, no new item is accepted until the sequencer is back in idle:
// the generator makes draws of SHIFTS_PER_DRAW shifts each, at up to eight shifts per
// cycle, until a draw yields an odd mask, after which the three byte lanes mask and
// multiply in two stages and the merge stage loads the output register. A generator
// that yields no odd mask in 128 draws returns zero bytes with the stuck error flag set;
// the lane stages are skipped. A result waiting in the output register does not stop
// the next item being accepted and worked on; only the merge of that next item waits
// while the earlier result stays stalled.

module masked_hill_cipher_3byte_top
    import mhc_pkg::*;
#(
    parameter int SHIFTS_PER_DRAW = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input channel.
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_operation,
    input  logic [7:0]            i_in_byte_first,
    input  logic [7:0]            i_in_byte_second,
    input  logic [7:0]            i_in_byte_third,
    // Output channel.
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_out_byte_first,
    output logic [7:0]            o_out_byte_second,
    output logic [7:0]            o_out_byte_third,
    output logic                  o_stuck_error
);

    localparam int LEFT_W = $clog2(SHIFTS_PER_DRAW + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DRAW  = 5'b00010,
        S_MASK  = 5'b00100,
        S_PROD  = 5'b01000,
        S_MERGE = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [LEFT_W-1:0]   r_left, n_left;
    logic [DRAW_W-1:0]   r_draws, n_draws;
    logic                r_stuck, n_stuck;
    t_byte               r_factor, n_factor;
    logic                r_op;
    t_byte3              r_in;
    logic [KEY_ROW_W-1:0] r_key_row [3];
    logic                r_out_valid;
    t_byte3              r_out_bytes;
    logic                r_out_stuck;

    t_gen_ctrl           w_gen_ctrl;
    t_lane_ctrl          w_lane_ctrl;
    t_byte               w_next_low;
    logic [STEP_W-1:0]   w_steps;
    logic                w_draw_done;
    logic                w_in_xfer;
    logic                w_out_xfer;
    logic                w_out_load;
    t_byte3              w_key_col [3];
    t_byte3              w_prod [3];
    t_byte3              w_merged;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_xfer = r_out_valid && !i_out_stall;
    assign w_out_load = (r_state == S_MERGE) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = (r_state != S_IDLE);

    // Shifts this cycle: eight, or whatever remains of the current draw.
    assign w_draw_done = (int'(r_left) <= SHIFTS_PER_CYCLE);
    assign w_steps     = w_draw_done ? STEP_W'(r_left) : STEP_W'(SHIFTS_PER_CYCLE);

    // Generator control: seed writes must come only while idle; the block itself does not enforce this.
    always_comb begin
        w_gen_ctrl              = '0;
        w_gen_ctrl.seed_low_we  = i_cfg_we && (i_cfg_index == CFG_SEED_LOW);
        w_gen_ctrl.seed_high_we = i_cfg_we && (i_cfg_index == CFG_SEED_HIGH);
        w_gen_ctrl.shift_en     = (r_state == S_DRAW);
        w_gen_ctrl.steps        = (r_state == S_DRAW) ? w_steps : '0;
    end

    assign w_lane_ctrl.mask_en = (r_state == S_MASK);
    assign w_lane_ctrl.prod_en = (r_state == S_PROD);

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_left   = r_left;
        n_draws  = r_draws;
        n_stuck  = r_stuck;
        n_factor = r_factor;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_DRAW;
                    n_left  = LEFT_W'(SHIFTS_PER_DRAW);
                    n_draws = '0;
                    n_stuck = 1'b0;
                end
            end
            S_DRAW: begin
                if (!w_draw_done) begin
                    n_left = r_left - LEFT_W'(w_steps);
                end else if (w_next_low[0]) begin
                    n_factor = (r_op == OP_UNLOCK) ? INV_TABLE[w_next_low[7:1]] : w_next_low;
                    n_state  = S_MASK;
                end else if (r_draws == DRAW_W'(MAX_DRAWS - 1)) begin
                    n_stuck = 1'b1;
                    n_state = S_MERGE;
                end else begin
                    n_draws = r_draws + DRAW_W'(1);
                    n_left  = LEFT_W'(SHIFTS_PER_DRAW);
                end
            end
            S_MASK: begin
                n_state = S_PROD;
            end
            S_PROD: begin
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
            r_draws <= '0;
            r_stuck <= 1'b0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_draws <= n_draws;
            r_stuck <= n_stuck;
        end
    end

    // Factor and captured input triple.
    always_ff @(posedge i_clk) begin
        r_factor <= n_factor;
        if (w_in_xfer) begin
            r_op    <= i_operation;
            r_in[0] <= i_in_byte_first;
            r_in[1] <= i_in_byte_second;
            r_in[2] <= i_in_byte_third;
        end
    end

    // Key matrix rows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_row[0] <= KEY_ROW_W'(24'h000001);
            r_key_row[1] <= KEY_ROW_W'(24'h000100);
            r_key_row[2] <= KEY_ROW_W'(24'h010000);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_ROW_FIRST:  r_key_row[0] <= i_cfg_data[KEY_ROW_W-1:0];
                CFG_KEY_ROW_SECOND: r_key_row[1] <= i_cfg_data[KEY_ROW_W-1:0];
                CFG_KEY_ROW_THIRD:  r_key_row[2] <= i_cfg_data[KEY_ROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Column c of the key matrix goes to lane c.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                w_key_col[c][r] = r_key_row[r][8*c +: 8];
            end
        end
    end

    mhc_lfsr u_lfsr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_gen_ctrl),
        .i_seed_data (i_cfg_data),
        .o_next_low  (w_next_low)
    );

    for (genvar g = 0; g < 3; g++) begin : g_lane
        mhc_lane u_lane (
            .i_clk     (i_clk),
            .i_ctrl    (w_lane_ctrl),
            .i_byte    (r_in[g]),
            .i_factor  (r_factor),
            .i_key_col (w_key_col[g]),
            .o_prod    (w_prod[g])
        );
    end

    mhc_merge u_merge (
        .i_prod  (w_prod),
        .i_stuck (r_stuck),
        .o_bytes (w_merged)
    );

    // Output register: holds a result until its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (w_out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_bytes <= w_merged;
            r_out_stuck <= r_stuck;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_byte_first  = r_out_bytes[0];
    assign o_out_byte_second = r_out_bytes[1];
    assign o_out_byte_third  = r_out_bytes[2];
    assign o_stuck_error     = r_out_stuck;

    // A stuck result always carries zero bytes.
    a_stuck_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_stuck) |->
            (r_out_bytes[0] == '0 && r_out_bytes[1] == '0 && r_out_bytes[2] == '0))
        else $error("stuck result with non-zero bytes");

    // A draw in progress always has shifts left to do.
    a_draw_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAW) |-> (r_left != '0))
        else $error("draw state with no shifts remaining");

    // An accepted item starts a fresh draw of the full length.
    a_accept_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_DRAW && r_left == LEFT_W'(SHIFTS_PER_DRAW)
                       && r_draws == '0))
        else $error("accepted item did not start a draw");

    // The merge stage waits while a held result is stalled.
    a_merge_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MERGE && r_out_valid && i_out_stall) |=>
            (r_state == S_MERGE && $stable(r_out_bytes)))
        else $error("result overwritten while output stalled");

endmodule
